/* hw/rtl/fixed_capacity_multiset_table_defines.svh */
// assertion macros for the multiset table
`ifndef FIXED_CAPACITY_MULTISET_TABLE_DEFINES_SVH
`define FIXED_CAPACITY_MULTISET_TABLE_DEFINES_SVH

// same-cycle implication
`define FCMT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcmt assertion failed");

// next-cycle implication
`define FCMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcmt assertion failed");

`endif

/* hw/rtl/fcmt_pkg.sv */
// shared constants and types for the multiset table
`timescale 1ns / 1ps
`default_nettype none
package fcmt_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMD_W       = 2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd3;

  typedef struct packed {
    logic                   we;
    logic [IDX_W-1:0]       addr;
    logic [VALUE_WIDTH-1:0] data;
  } fcmt_wr_t;

endpackage
`default_nettype wire

/* hw/rtl/fcmt_ram.sv */
// entry store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module fcmt_ram (
  input  wire logic                               clk,
  input  wire fcmt_pkg::fcmt_wr_t                 wr,
  input  wire logic [fcmt_pkg::IDX_W-1:0]         raddr,
  output logic      [fcmt_pkg::VALUE_WIDTH-1:0]   rdata_r
);

  logic [fcmt_pkg::VALUE_WIDTH-1:0] mem [fcmt_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/fixed_capacity_multiset_table.sv */
// top level: bag of values with add, remove, find and count commands
//
// input channel in_valid/in_stall carries in_cmd and in_value; one result per
// transaction leaves on out_valid/out_stall with out_ok, out_position,
// out_occurrences, out_size_now and out_is_empty.
// add writes the new entry when accepted and needs no scan. remove, find and
// count walk the stored entries one per cycle through a single comparator fed
// by the entry memory read port, stopping early at the first match for find
// and remove; remove then moves the last entry into the freed slot. an empty
// bag answers without a scan. in_stall is high while a command is worked on.
// the result sits in an output register; a new transaction is accepted while
// it waits, and the next result waits for the register to free up while
// out_stall is high. synchronous active-low reset empties the bag and drops
// any pending result; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_capacity_multiset_table_defines.svh"
module fixed_capacity_multiset_table (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [fcmt_pkg::CMD_W-1:0]           in_cmd,
  input  wire logic [fcmt_pkg::VALUE_WIDTH-1:0]     in_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_ok,
  output logic      [fcmt_pkg::IDX_W-1:0]           out_position,
  output logic      [fcmt_pkg::CNT_W-1:0]           out_occurrences,
  output logic      [fcmt_pkg::CNT_W-1:0]           out_size_now,
  output logic                                      out_is_empty
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_MOVEW = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                         state_r, state_nxt;
  logic [fcmt_pkg::CMD_W-1:0]         cmd_r, cmd_nxt;
  logic [fcmt_pkg::VALUE_WIDTH-1:0]   value_r, value_nxt;
  logic [fcmt_pkg::CNT_W-1:0]         fill_r, fill_nxt;
  logic [fcmt_pkg::CNT_W-1:0]         addr_r, addr_nxt;
  logic                               rvalid_r, rvalid_nxt;
  logic [fcmt_pkg::IDX_W-1:0]         cidx_r, cidx_nxt;
  logic                               ok_r, ok_nxt;
  logic [fcmt_pkg::IDX_W-1:0]         pos_r, pos_nxt;
  logic [fcmt_pkg::CNT_W-1:0]         occ_r, occ_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_ok_r, out_ok_nxt;
  logic [fcmt_pkg::IDX_W-1:0]         out_pos_r, out_pos_nxt;
  logic [fcmt_pkg::CNT_W-1:0]         out_occ_r, out_occ_nxt;
  logic [fcmt_pkg::CNT_W-1:0]         out_size_r, out_size_nxt;
  logic                               out_empty_r, out_empty_nxt;

  fcmt_pkg::fcmt_wr_t                 wr;
  logic [fcmt_pkg::IDX_W-1:0]         raddr;
  logic [fcmt_pkg::VALUE_WIDTH-1:0]   rdata_r;
  logic                               eq;
  logic [fcmt_pkg::CNT_W-1:0]         last_idx;

  fcmt_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .raddr   (raddr),
    .rdata_r (rdata_r)
  );

  // shared comparator
  assign eq       = (rdata_r == value_r);
  assign last_idx = fill_r - fcmt_pkg::CNT_W'(1);

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    value_nxt     = value_r;
    fill_nxt      = fill_r;
    addr_nxt      = addr_r;
    rvalid_nxt    = 1'b0;
    cidx_nxt      = cidx_r;
    ok_nxt        = ok_r;
    pos_nxt       = pos_r;
    occ_nxt       = occ_r;
    out_ok_nxt    = out_ok_r;
    out_pos_nxt   = out_pos_r;
    out_occ_nxt   = out_occ_r;
    out_size_nxt  = out_size_r;
    out_empty_nxt = out_empty_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr.we         = 1'b0;
    wr.addr       = fill_r[fcmt_pkg::IDX_W-1:0];
    wr.data       = in_value;
    raddr         = addr_r[fcmt_pkg::IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          value_nxt = in_value;
          ok_nxt    = 1'b0;
          pos_nxt   = '0;
          occ_nxt   = '0;
          addr_nxt  = '0;
          if (in_cmd == fcmt_pkg::CMD_ADD) begin
            if (fill_r < fcmt_pkg::CAP_CNT) begin
              wr.we    = 1'b1;
              fill_nxt = fill_r + fcmt_pkg::CNT_W'(1);
              ok_nxt   = 1'b1;
            end
            state_nxt = S_DONE;
          end else if (fill_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (addr_r < fill_r) begin
          rvalid_nxt = 1'b1;
          cidx_nxt   = addr_r[fcmt_pkg::IDX_W-1:0];
          addr_nxt   = addr_r + fcmt_pkg::CNT_W'(1);
        end
        if (rvalid_r) begin
          if (eq && (cmd_r == fcmt_pkg::CMD_COUNT)) begin
            occ_nxt = occ_r + fcmt_pkg::CNT_W'(1);
          end
          if (eq && (cmd_r != fcmt_pkg::CMD_COUNT)) begin
            ok_nxt     = 1'b1;
            pos_nxt    = cidx_r;
            rvalid_nxt = 1'b0;
            if (cmd_r == fcmt_pkg::CMD_REMOVE) begin
              fill_nxt  = last_idx;
              state_nxt = S_MOVE;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (cidx_r == last_idx[fcmt_pkg::IDX_W-1:0]) begin
            rvalid_nxt = 1'b0;
            state_nxt  = S_DONE;
          end
        end
      end
      S_MOVE: begin
        // fetch the old last entry
        raddr     = fill_r[fcmt_pkg::IDX_W-1:0];
        state_nxt = S_MOVEW;
      end
      S_MOVEW: begin
        wr.we     = 1'b1;
        wr.addr   = pos_r;
        wr.data   = rdata_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = (cmd_r == fcmt_pkg::CMD_COUNT) ? (occ_r != '0) : ok_r;
          out_pos_nxt   = (cmd_r == fcmt_pkg::CMD_FIND) ? pos_r : '0;
          out_occ_nxt   = occ_r;
          out_size_nxt  = fill_r;
          out_empty_nxt = (fill_r == '0);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    value_r     <= value_nxt;
    addr_r      <= addr_nxt;
    cidx_r      <= cidx_nxt;
    ok_r        <= ok_nxt;
    pos_r       <= pos_nxt;
    occ_r       <= occ_nxt;
    out_ok_r    <= out_ok_nxt;
    out_pos_r   <= out_pos_nxt;
    out_occ_r   <= out_occ_nxt;
    out_size_r  <= out_size_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_position    = out_pos_r;
  assign out_occurrences = out_occ_r;
  assign out_size_now    = out_size_r;
  assign out_is_empty    = out_empty_r;

  `FCMT_ASSERT_NOW(a_fill_max, 1'b1, fill_r <= fcmt_pkg::CAP_CNT)
  `FCMT_ASSERT_NOW(a_scan_nonempty, state_r == S_SCAN, fill_r != '0)
  `FCMT_ASSERT_NEXT(a_add_grows, in_valid && !in_stall && (in_cmd == fcmt_pkg::CMD_ADD) && (fill_r < fcmt_pkg::CAP_CNT), fill_r == $past(fill_r) + fcmt_pkg::CNT_W'(1))
  `FCMT_ASSERT_NOW(a_empty_flag, out_valid_r, out_empty_r == (out_size_r == '0))

endmodule
`default_nettype wire

/* tb/multiset_result_check.sv */
// result checker for the multiset table: tracks the bag contents and compares each result
`timescale 1ns / 1ps
module multiset_result_check (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_stall,
  input  wire logic [fcmt_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [fcmt_pkg::VALUE_WIDTH-1:0]   in_value,
  input  wire logic                               out_valid,
  input  wire logic                               out_stall,
  input  wire logic                               out_ok,
  input  wire logic [fcmt_pkg::IDX_W-1:0]         out_position,
  input  wire logic [fcmt_pkg::CNT_W-1:0]         out_occurrences,
  input  wire logic [fcmt_pkg::CNT_W-1:0]         out_size_now,
  input  wire logic                               out_is_empty,
  output int                                      mismatches,
  output int                                      pending,
  output int                                      checked,
  output int                                      full_rejects
);

  typedef struct packed {
    logic                         ok;
    logic [fcmt_pkg::IDX_W-1:0]   position;
    logic [fcmt_pkg::CNT_W-1:0]   occurrences;
    logic [fcmt_pkg::CNT_W-1:0]   size_now;
    logic                         is_empty;
  } bag_result_t;

  typedef struct {
    logic [fcmt_pkg::CMD_W-1:0]       cmd;
    logic [fcmt_pkg::VALUE_WIDTH-1:0] value;
    bag_result_t                      result;
  } bag_answer_t;

  logic [fcmt_pkg::VALUE_WIDTH-1:0] bag_mem [fcmt_pkg::CAPACITY];
  int          bag_fill = 0;
  int          n_bad = 0;
  int          n_checked = 0;
  int          n_full = 0;
  bag_answer_t answers_due [$];

  task automatic apply_bag_command(input logic [fcmt_pkg::CMD_W-1:0] cmd,
                                   input logic [fcmt_pkg::VALUE_WIDTH-1:0] value,
                                   output bag_result_t r);
    int first_hit;
    int hits;
    first_hit = -1;
    hits = 0;
    for (int i = 0; i < bag_fill; i++) begin
      if (bag_mem[i] == value) begin
        hits++;
        if (first_hit < 0) first_hit = i;
      end
    end
    r = '0;
    case (cmd)
      fcmt_pkg::CMD_ADD: begin
        if (bag_fill < fcmt_pkg::CAPACITY) begin
          bag_mem[bag_fill] = value;
          bag_fill++;
          r.ok = 1'b1;
        end else begin
          n_full++;
        end
      end
      fcmt_pkg::CMD_REMOVE: begin
        if (first_hit >= 0) begin
          bag_fill--;
          bag_mem[first_hit] = bag_mem[bag_fill];
          r.ok = 1'b1;
        end
      end
      fcmt_pkg::CMD_FIND: begin
        if (first_hit >= 0) begin
          r.ok = 1'b1;
          r.position = first_hit[fcmt_pkg::IDX_W-1:0];
        end
      end
      default: begin
        r.occurrences = hits[fcmt_pkg::CNT_W-1:0];
        r.ok = (hits != 0);
      end
    endcase
    r.size_now = bag_fill[fcmt_pkg::CNT_W-1:0];
    r.is_empty = (bag_fill == 0);
  endtask

  always @(posedge clk) begin
    bag_answer_t want;
    bag_answer_t fresh;
    bag_result_t got;
    if (!rst_n) begin
      bag_fill = 0;
      answers_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_ok, out_position, out_occurrences, out_size_now, out_is_empty};
        if (answers_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: unexpected result transaction ok=%0d pos=%0d occ=%0d size=%0d %s%0d",
                     $realtime, got.ok, got.position, got.occurrences, got.size_now,
                     "empty=", got.is_empty);
        end else begin
          want = answers_due.pop_front();
          n_checked++;
          if (got.ok !== want.result.ok || got.position !== want.result.position ||
              got.occurrences !== want.result.occurrences ||
              got.size_now !== want.result.size_now ||
              got.is_empty !== want.result.is_empty) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: mismatch on cmd %0d value %h", $realtime, want.cmd, want.value);
              $display("  expected ok=%0d pos=%0d occ=%0d size=%0d empty=%0d",
                       want.result.ok, want.result.position, want.result.occurrences,
                       want.result.size_now, want.result.is_empty);
              $display("  actual   ok=%0d pos=%0d occ=%0d size=%0d empty=%0d",
                       got.ok, got.position, got.occurrences, got.size_now, got.is_empty);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        fresh.cmd = in_cmd;
        fresh.value = in_value;
        apply_bag_command(in_cmd, in_value, fresh.result);
        answers_due.insert(answers_due.size(), fresh);
      end
    end
    pending      <= answers_due.size();
    mismatches   <= n_bad;
    checked      <= n_checked;
    full_rejects <= n_full;
  end

endmodule

/* tb/tb_top.sv */
// testbench top: drives command transactions into the multiset table and gives the verdict
`timescale 1ns / 1ps
module tb_top;

  localparam int IDLE_PCT       = 34;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 200;
  localparam int POOL_SIZE      = 6;
  localparam int SETTLE_CYCLES  = 80;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic [fcmt_pkg::CMD_W-1:0]          in_cmd = fcmt_pkg::CMD_ADD;
  logic [fcmt_pkg::VALUE_WIDTH-1:0]    in_value = '0;
  logic                                out_stall = 1'b0;
  logic                                in_stall;
  logic                                out_valid;
  logic                                out_ok;
  logic [fcmt_pkg::IDX_W-1:0]          out_position;
  logic [fcmt_pkg::CNT_W-1:0]          out_occurrences;
  logic [fcmt_pkg::CNT_W-1:0]          out_size_now;
  logic                                out_is_empty;

  int mismatches;
  int pending;
  int checked;
  int full_rejects;
  bit quiet = 1'b0;
  int cmd_sent [4] = '{0, 0, 0, 0};

  logic [fcmt_pkg::VALUE_WIDTH-1:0] value_pool [POOL_SIZE];
  logic [fcmt_pkg::VALUE_WIDTH-1:0] added_vals [$];

  // per phase command mix and value sourcing, in percent
  int add_w  [PHASES] = '{35, 75, 35, 15, 70, 10, 10, 35};
  int rem_w  [PHASES] = '{25,  5, 25, 55,  5, 10, 60, 25};
  int find_w [PHASES] = '{20, 10, 20, 15, 15, 40, 15, 20};
  int pool_w [PHASES] = '{60, 50, 50, 30,  0, 30, 40, 20};
  int hist_w [PHASES] = '{30, 30, 30, 60, 50, 60, 50, 30};

  always #10 clk = ~clk;

  fixed_capacity_multiset_table i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_position    (out_position),
    .out_occurrences (out_occurrences),
    .out_size_now    (out_size_now),
    .out_is_empty    (out_is_empty)
  );

  multiset_result_check i_bag_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_position    (out_position),
    .out_occurrences (out_occurrences),
    .out_size_now    (out_size_now),
    .out_is_empty    (out_is_empty),
    .mismatches      (mismatches),
    .pending         (pending),
    .checked         (checked),
    .full_rejects    (full_rejects)
  );

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic send_command(input logic [fcmt_pkg::CMD_W-1:0] cmd,
                              input logic [fcmt_pkg::VALUE_WIDTH-1:0] value);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      in_cmd   <= fcmt_pkg::CMD_W'($urandom);
      in_value <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    cmd_sent[cmd]++;
    if (cmd == fcmt_pkg::CMD_ADD) begin
      added_vals.insert(added_vals.size(), value);
      if (added_vals.size() > fcmt_pkg::CAPACITY) void'(added_vals.pop_front());
    end
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [fcmt_pkg::CMD_W-1:0] pick_cmd(int p);
    int r;
    r = $urandom_range(99);
    if (r < add_w[p]) return fcmt_pkg::CMD_ADD;
    if (r < add_w[p] + rem_w[p]) return fcmt_pkg::CMD_REMOVE;
    if (r < add_w[p] + rem_w[p] + find_w[p]) return fcmt_pkg::CMD_FIND;
    return fcmt_pkg::CMD_COUNT;
  endfunction

  function automatic logic [fcmt_pkg::VALUE_WIDTH-1:0] pick_value(int p);
    int r;
    r = $urandom_range(99);
    if (r < pool_w[p]) return value_pool[$urandom_range(POOL_SIZE - 1)];
    if (r < pool_w[p] + hist_w[p] && added_vals.size() > 0)
      return added_vals[$urandom_range(added_vals.size() - 1)];
    return $urandom;
  endfunction

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [fcmt_pkg::VALUE_WIDTH-1:0] ones;
    logic [fcmt_pkg::VALUE_WIDTH-1:0] absent;
    ones = '1;
    absent = 32'h5a5a_a5a5;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty bag, duplicates, first-match remove, misses, last-entry remove
    send_command(fcmt_pkg::CMD_COUNT,  '0);
    send_command(fcmt_pkg::CMD_FIND,   ones);
    send_command(fcmt_pkg::CMD_REMOVE, '0);
    send_command(fcmt_pkg::CMD_ADD,    '0);
    send_command(fcmt_pkg::CMD_ADD,    ones);
    send_command(fcmt_pkg::CMD_ADD,    '0);
    send_command(fcmt_pkg::CMD_FIND,   '0);
    send_command(fcmt_pkg::CMD_FIND,   ones);
    send_command(fcmt_pkg::CMD_COUNT,  '0);
    send_command(fcmt_pkg::CMD_COUNT,  ones);
    send_command(fcmt_pkg::CMD_REMOVE, '0);
    send_command(fcmt_pkg::CMD_COUNT,  '0);
    send_command(fcmt_pkg::CMD_FIND,   absent);
    send_command(fcmt_pkg::CMD_REMOVE, absent);
    send_command(fcmt_pkg::CMD_REMOVE, ones);
    send_command(fcmt_pkg::CMD_REMOVE, '0);
    send_command(fcmt_pkg::CMD_COUNT,  '0);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      value_pool[0] = '0;
      value_pool[1] = '1;
      for (int k = 2; k < POOL_SIZE; k++) value_pool[k] = $urandom;
      quiet = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) send_command(pick_cmd(p), pick_value(p));
      drain_results();
    end
    quiet = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d add, %0d remove, %0d find and %0d count transactions",
             cmd_sent[fcmt_pkg::CMD_ADD], cmd_sent[fcmt_pkg::CMD_REMOVE],
             cmd_sent[fcmt_pkg::CMD_FIND], cmd_sent[fcmt_pkg::CMD_COUNT]);
    $display("%0d results checked, %0d adds refused on a full bag, %0d mismatches",
             checked, full_rejects, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
